// ===== hw/rtl/mtic_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mtic_pkg
// Shared widths, constants and small modular helpers for the triplet index
// codec: word-list size, reciprocal for constant division, request kinds.
// ----------------------------------------------------------------------------
package mtic_pkg;

   // Word-list size N, legal from 2 to 2048.
   localparam int unsigned WORD_LIST_SIZE = 1626;

   localparam int unsigned WORD_WIDTH = 32;
   localparam int unsigned IDX_WIDTH  = 11;
   localparam int unsigned PROD_WIDTH = 2 * WORD_WIDTH;
   // N <= 2^IDX_WIDTH, so a decoded value below N^3 fits in three index widths.
   localparam int unsigned DEC_WIDTH  = 3 * IDX_WIDTH;

   // floor(2^32 / N): the quotient estimate is low by at most one.
   localparam logic [WORD_WIDTH-1:0] DIV_RECIP =
      WORD_WIDTH'((64'd1 << WORD_WIDTH) / WORD_LIST_SIZE);

   localparam logic [WORD_WIDTH-1:0]  LIST_SIZE_W  = WORD_WIDTH'(WORD_LIST_SIZE);
   localparam logic [IDX_WIDTH:0]     LIST_SIZE    = (IDX_WIDTH + 1)'(WORD_LIST_SIZE);
   localparam logic [2*IDX_WIDTH:0]   LIST_SIZE_SQ =
      (2 * IDX_WIDTH + 1)'(WORD_LIST_SIZE * WORD_LIST_SIZE);

   typedef enum logic {
      REQ_ENCODE = 1'b0,
      REQ_DECODE = 1'b1
   } kind_type;

   // (x + y) mod N for x, y already below N.
   function automatic logic [IDX_WIDTH-1:0] mod_add(input logic [IDX_WIDTH-1:0] x,
                                                    input logic [IDX_WIDTH-1:0] y);
      logic [IDX_WIDTH:0] sum;
      sum = {1'b0, x} + {1'b0, y};
      if (sum >= LIST_SIZE) begin
         sum = sum - LIST_SIZE;
      end
      return sum[IDX_WIDTH-1:0];
   endfunction

   // Floored (x - y) mod N for x, y already below N.
   function automatic logic [IDX_WIDTH-1:0] diff_mod(input logic [IDX_WIDTH-1:0] x,
                                                     input logic [IDX_WIDTH-1:0] y);
      logic [IDX_WIDTH:0] sum;
      sum = {1'b0, x} + LIST_SIZE - {1'b0, y};
      if (sum >= LIST_SIZE) begin
         sum = sum - LIST_SIZE;
      end
      return sum[IDX_WIDTH-1:0];
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/mtic_divmod.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mtic_divmod
// Two-stage divide of a 32-bit word by the word-list size: reciprocal
// multiply, then back-multiply and a single correction step.
// ----------------------------------------------------------------------------
module mtic_divmod (
   input  wire logic                            clock,
   input  wire logic [mtic_pkg::WORD_WIDTH-1:0] dividend,
   output logic      [mtic_pkg::WORD_WIDTH-1:0] quotient,
   output logic      [mtic_pkg::IDX_WIDTH-1:0]  remainder
);
   import mtic_pkg::*;

   logic [PROD_WIDTH-1:0] product_ff;
   logic [WORD_WIDTH-1:0] dividend_ff;
   logic [WORD_WIDTH-1:0] q_est;
   logic [WORD_WIDTH-1:0] back;
   logic [WORD_WIDTH-1:0] r_tmp;
   logic [WORD_WIDTH-1:0] quotient_in;
   logic [WORD_WIDTH-1:0] quotient_ff;
   logic [IDX_WIDTH-1:0]  remainder_in;
   logic [IDX_WIDTH-1:0]  remainder_ff;

   always_ff @(posedge clock) begin
      product_ff  <= PROD_WIDTH'(dividend) * PROD_WIDTH'(DIV_RECIP);
      dividend_ff <= dividend;
   end

   // Estimate is q or q-1; one compare and subtract fixes it.
   always_comb begin
      q_est = product_ff[PROD_WIDTH-1:WORD_WIDTH];
      back  = q_est * LIST_SIZE_W;
      r_tmp = dividend_ff - back;
      if (r_tmp >= LIST_SIZE_W) begin
         quotient_in  = q_est + WORD_WIDTH'(1);
         remainder_in = IDX_WIDTH'(r_tmp - LIST_SIZE_W);
      end else begin
         quotient_in  = q_est;
         remainder_in = IDX_WIDTH'(r_tmp);
      end
   end

   always_ff @(posedge clock) begin
      quotient_ff  <= quotient_in;
      remainder_ff <= remainder_in;
   end

   assign quotient  = quotient_ff;
   assign remainder = remainder_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/mnemonic_triplet_index_codec.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mnemonic_triplet_index_codec
// Converts a 32-bit entropy word to three chained word-list indices, or a
// triplet of indices back to the word with an overflow flag.
// ----------------------------------------------------------------------------
// Usage: a request transfers on any clock edge with start high and busy low;
// busy is high only during reset and the cycle after it, so one request can
// transfer every clock. Each request gives exactly one result, shown for one
// cycle with rsp_strobe high; the receiver cannot stall, so capture it then.
// The pipeline depth is set by three chained divides by the word-list size
// (two stages each: reciprocal multiply, then back-multiply and correct) plus
// one output stage. Index inputs at or above the word-list size are reduced
// modulo it first. Fields of the unused mode read zero.
module mnemonic_triplet_index_codec (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic                            req_type,
   input  wire logic [mtic_pkg::WORD_WIDTH-1:0] req_entropy_word,
   input  wire logic [mtic_pkg::IDX_WIDTH-1:0]  req_first_index,
   input  wire logic [mtic_pkg::IDX_WIDTH-1:0]  req_second_index,
   input  wire logic [mtic_pkg::IDX_WIDTH-1:0]  req_third_index,
   output logic                                 rsp_strobe,
   output logic      [mtic_pkg::WORD_WIDTH-1:0] rsp_word_out,
   output logic                                 rsp_overflowed,
   output logic      [mtic_pkg::IDX_WIDTH-1:0]  rsp_index_a,
   output logic      [mtic_pkg::IDX_WIDTH-1:0]  rsp_index_b,
   output logic      [mtic_pkg::IDX_WIDTH-1:0]  rsp_index_c
);
   import mtic_pkg::*;

   localparam int unsigned PAD_WIDTH = WORD_WIDTH - IDX_WIDTH;

   logic                  busy_ff;
   logic                  accept;
   kind_type              req_kind;

   // Valid and kind travel with the data through stages 1..6.
   logic [6:1]            valid_ff;
   kind_type              kind_ff [1:6];

   logic [WORD_WIDTH-1:0] u0_dividend;
   logic [WORD_WIDTH-1:0] u0_quo;
   logic [IDX_WIDTH-1:0]  u0_rem;
   logic [WORD_WIDTH-1:0] u1_quo;
   logic [IDX_WIDTH-1:0]  u1_rem;
   logic [WORD_WIDTH-1:0] u2_quo;
   logic [IDX_WIDTH-1:0]  u2_rem;
   logic [WORD_WIDTH-1:0] u3_quo;
   logic [IDX_WIDTH-1:0]  u3_rem;
   logic [WORD_WIDTH-1:0] u4_quo;
   logic [IDX_WIDTH-1:0]  u4_rem;

   logic [IDX_WIDTH-1:0]   a_ff3, a_ff4, a_ff5, a_ff6;
   logic [IDX_WIDTH-1:0]   d1_ff3, d2_ff3;
   logic [2*IDX_WIDTH-1:0] p1_ff4;
   logic [DEC_WIDTH-1:0]   p2_ff4;
   logic [IDX_WIDTH-1:0]   b_ff5, b_ff6;
   logic [DEC_WIDTH-1:0]   v_ff5, v_ff6;

   logic                  rsp_strobe_ff;
   logic [WORD_WIDTH-1:0] rsp_word_out_in,   rsp_word_out_ff;
   logic                  rsp_overflowed_in, rsp_overflowed_ff;
   logic [IDX_WIDTH-1:0]  rsp_index_a_in,    rsp_index_a_ff;
   logic [IDX_WIDTH-1:0]  rsp_index_b_in,    rsp_index_b_ff;
   logic [IDX_WIDTH-1:0]  rsp_index_c_in,    rsp_index_c_ff;

   // Hold off requests only around reset; the pipeline never stalls.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy     = busy_ff;
   assign accept   = start & ~busy_ff;
   assign req_kind = kind_type'(req_type);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[5:1], accept};
      end
   end

   always_ff @(posedge clock) begin
      kind_ff[1] <= req_kind;
      for (int i = 2; i <= 6; i++) begin
         kind_ff[i] <= kind_ff[i-1];
      end
   end

   // Stages 1-2: divide the word (encode) or reduce all three indices (decode).
   assign u0_dividend = (req_kind == REQ_DECODE) ? {{PAD_WIDTH{1'b0}}, req_first_index}
                                                 : req_entropy_word;

   mtic_divmod u_div0 (
      .clock     (clock),
      .dividend  (u0_dividend),
      .quotient  (u0_quo),
      .remainder (u0_rem)
   );

   mtic_divmod u_div1 (
      .clock     (clock),
      .dividend  ({{PAD_WIDTH{1'b0}}, req_second_index}),
      .quotient  (u1_quo),
      .remainder (u1_rem)
   );

   mtic_divmod u_div2 (
      .clock     (clock),
      .dividend  ({{PAD_WIDTH{1'b0}}, req_third_index}),
      .quotient  (u2_quo),
      .remainder (u2_rem)
   );

   // Stages 3-4: second divide gives v/N^2 and (v/N) mod N.
   mtic_divmod u_div3 (
      .clock     (clock),
      .dividend  (u0_quo),
      .quotient  (u3_quo),
      .remainder (u3_rem)
   );

   // Stages 5-6: third divide gives (v/N^2) mod N.
   mtic_divmod u_div4 (
      .clock     (clock),
      .dividend  (u3_quo),
      .quotient  (u4_quo),
      .remainder (u4_rem)
   );

   // Side path: floored differences, products and sum for decode; chained
   // offsets for encode.
   always_ff @(posedge clock) begin
      // stage 3
      a_ff3  <= u0_rem;
      d1_ff3 <= diff_mod(u1_rem, u0_rem);
      d2_ff3 <= diff_mod(u2_rem, u1_rem);
      // stage 4
      a_ff4  <= a_ff3;
      p1_ff4 <= (2 * IDX_WIDTH)'(d1_ff3) * (2 * IDX_WIDTH)'(LIST_SIZE);
      p2_ff4 <= DEC_WIDTH'(d2_ff3) * DEC_WIDTH'(LIST_SIZE_SQ);
      // stage 5
      a_ff5  <= a_ff4;
      b_ff5  <= mod_add(u3_rem, a_ff4);
      v_ff5  <= DEC_WIDTH'(a_ff4) + DEC_WIDTH'(p1_ff4) + p2_ff4;
      // stage 6
      a_ff6  <= a_ff5;
      b_ff6  <= b_ff5;
      v_ff6  <= v_ff5;
   end

   // Stage 7: pick the fields of the request's mode, zero the others.
   always_comb begin
      unique case (kind_ff[6])
         REQ_DECODE: begin
            rsp_word_out_in   = v_ff6[WORD_WIDTH-1:0];
            rsp_overflowed_in = |v_ff6[DEC_WIDTH-1:WORD_WIDTH];
            rsp_index_a_in    = '0;
            rsp_index_b_in    = '0;
            rsp_index_c_in    = '0;
         end
         REQ_ENCODE: begin
            rsp_word_out_in   = '0;
            rsp_overflowed_in = 1'b0;
            rsp_index_a_in    = a_ff6;
            rsp_index_b_in    = b_ff6;
            rsp_index_c_in    = mod_add(u4_rem, b_ff6);
         end
         default: begin
            rsp_word_out_in   = '0;
            rsp_overflowed_in = 1'b0;
            rsp_index_a_in    = '0;
            rsp_index_b_in    = '0;
            rsp_index_c_in    = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= valid_ff[6];
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_out_ff   <= rsp_word_out_in;
      rsp_overflowed_ff <= rsp_overflowed_in;
      rsp_index_a_ff    <= rsp_index_a_in;
      rsp_index_b_ff    <= rsp_index_b_in;
      rsp_index_c_ff    <= rsp_index_c_in;
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_word_out   = rsp_word_out_ff;
   assign rsp_overflowed = rsp_overflowed_ff;
   assign rsp_index_a    = rsp_index_a_ff;
   assign rsp_index_b    = rsp_index_b_ff;
   assign rsp_index_c    = rsp_index_c_ff;

   // Every transfer yields its result strobe.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##7 rsp_strobe)
      else $error("result strobe missing seven cycles after request transfer");

   // Overflow comes only from a decode result, whose indices read zero.
   a_overflow_decode: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_overflowed) |->
         (rsp_index_a == '0 && rsp_index_b == '0 && rsp_index_c == '0))
      else $error("overflow flag on a result with nonzero indices");

   // Encoded indices always land below the word-list size.
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ({1'b0, rsp_index_a} < LIST_SIZE && {1'b0, rsp_index_b} < LIST_SIZE &&
                      {1'b0, rsp_index_c} < LIST_SIZE))
      else $error("result index not below word-list size");

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the triplet index codec: random and corner-case
// encode/decode requests, each predicted here and checked against the
// one-cycle response strobe.
// ----------------------------------------------------------------------------
module tb;
   import mtic_pkg::*;

   localparam int unsigned   HALF_PERIOD    = 4;
   localparam int unsigned   RESET_CYCLES   = 7;
   localparam int unsigned   TAIL_CYCLES    = 12;
   localparam int unsigned   WATCHDOG_LIMIT = 2000;
   localparam int unsigned   PHASE_ITEMS    = 200;
   localparam int unsigned   IDLE_NONE      = 0;
   localparam int unsigned   IDLE_HEAVY     = 77;
   localparam int unsigned   IDLE_LIGHT     = 23;
   localparam logic [63:0]   LIST_N         = 64'(WORD_LIST_SIZE);
   // N^3: every value below it has exactly one chained triplet.
   localparam logic [63:0]   TRIPLET_SPAN   = LIST_N * LIST_N * LIST_N;
   localparam logic [63:0]   WORD_MAX       = 64'hFFFF_FFFF;

   // One pending request, with the chance of the sender idling in front of it.
   typedef struct packed {
      kind_type                kind;
      logic [WORD_WIDTH-1:0]   entropy;
      logic [IDX_WIDTH-1:0]    idx0;
      logic [IDX_WIDTH-1:0]    idx1;
      logic [IDX_WIDTH-1:0]    idx2;
      logic [6:0]              idle_pct;
   } request_type;

   typedef struct packed {
      logic [IDX_WIDTH-1:0]    a;
      logic [IDX_WIDTH-1:0]    b;
      logic [IDX_WIDTH-1:0]    c;
   } triplet_type;

   // Expected response fields, plus the mode for the coverage summary.
   typedef struct packed {
      logic                    is_decode;
      logic [WORD_WIDTH-1:0]   word;
      logic                    ovf;
      triplet_type             idx;
   } response_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   kind_type                   req_type = REQ_ENCODE;
   logic [WORD_WIDTH-1:0]      req_entropy_word = '0;
   logic [IDX_WIDTH-1:0]       req_first_index = '0;
   logic [IDX_WIDTH-1:0]       req_second_index = '0;
   logic [IDX_WIDTH-1:0]       req_third_index = '0;
   logic                       rsp_strobe;
   logic [WORD_WIDTH-1:0]      rsp_word_out;
   logic                       rsp_overflowed;
   logic [IDX_WIDTH-1:0]       rsp_index_a;
   logic [IDX_WIDTH-1:0]       rsp_index_b;
   logic [IDX_WIDTH-1:0]       rsp_index_c;

   request_type                pending_requests[$];
   response_type               expected_responses[$];
   int unsigned                mismatches = 0;
   int unsigned                encodes_checked = 0;
   int unsigned                decodes_checked = 0;
   int unsigned                overflows_checked = 0;
   int unsigned                quiet_cycles = 0;

   mnemonic_triplet_index_codec uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_type         (req_type),
      .req_entropy_word (req_entropy_word),
      .req_first_index  (req_first_index),
      .req_second_index (req_second_index),
      .req_third_index  (req_third_index),
      .rsp_strobe       (rsp_strobe),
      .rsp_word_out     (rsp_word_out),
      .rsp_overflowed   (rsp_overflowed),
      .rsp_index_a      (rsp_index_a),
      .rsp_index_b      (rsp_index_b),
      .rsp_index_c      (rsp_index_c)
   );

   initial begin
      forever #HALF_PERIOD clock = ~clock;
   end

   // Chained base-N digits of a value: each digit offset by the one below it.
   // Also used to build well-formed decode triplets from a chosen value.
   function automatic triplet_type chain_indices(input logic [63:0] value);
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] c;
      a = value % LIST_N;
      b = (value / LIST_N + a) % LIST_N;
      c = (value / (LIST_N * LIST_N) + b) % LIST_N;
      return '{a: a[IDX_WIDTH-1:0], b: b[IDX_WIDTH-1:0], c: c[IDX_WIDTH-1:0]};
   endfunction

   // Expected response of the codec for one request.
   function automatic response_type predict_codec(input request_type req);
      response_type resp;
      logic [63:0]  a;
      logic [63:0]  b;
      logic [63:0]  c;
      logic [63:0]  value;
      resp = '0;
      if (req.kind == REQ_ENCODE) begin
         resp.idx = chain_indices(64'(req.entropy));
      end else begin
         // Reduce out-of-range indices first, then undo the chaining with
         // floored differences.
         a = 64'(req.idx0) % LIST_N;
         b = 64'(req.idx1) % LIST_N;
         c = 64'(req.idx2) % LIST_N;
         value = a + ((b + LIST_N - a) % LIST_N) * LIST_N
                   + ((c + LIST_N - b) % LIST_N) * LIST_N * LIST_N;
         resp.is_decode = 1'b1;
         resp.word      = value[WORD_WIDTH-1:0];
         resp.ovf       = (value > WORD_MAX);
      end
      return resp;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what,
               got, want);
      mismatches++;
   endtask

   task automatic queue_request(input kind_type kind, input logic [WORD_WIDTH-1:0] entropy,
                                input triplet_type idx, input int unsigned idle_pct);
      request_type item;
      item = '{kind: kind, entropy: entropy, idx0: idx.a, idx1: idx.b, idx2: idx.c,
               idle_pct: 7'(idle_pct)};
      pending_requests.insert(pending_requests.size(), item);
   endtask

   // Random noise for whichever fields the mode ignores, and raw 11-bit decode triplets.
   function automatic triplet_type random_indices();
      return '{a: IDX_WIDTH'($urandom), b: IDX_WIDTH'($urandom),
               c: IDX_WIDTH'($urandom)};
   endfunction

   // Fill one phase: mostly full-range words and well-formed triplets, with
   // some small words and raw 11-bit triplets for the out-of-range reduction.
   task automatic queue_random_phase(input int unsigned count, input int unsigned idle_pct);
      logic [63:0] value;
      for (int unsigned n = 0; n < count; n++) begin
         if ($urandom_range(1) == 0) begin
            if ($urandom_range(3) == 0) begin
               value = 64'($urandom_range(WORD_LIST_SIZE * WORD_LIST_SIZE));
            end else begin
               value = 64'($urandom);
            end
            queue_request(REQ_ENCODE, value[WORD_WIDTH-1:0], random_indices(), idle_pct);
         end else if ($urandom_range(9) < 7) begin
            value = {31'd0, 1'($urandom), 32'($urandom)} % TRIPLET_SPAN;
            queue_request(REQ_DECODE, $urandom, chain_indices(value), idle_pct);
         end else begin
            queue_request(REQ_DECODE, $urandom, random_indices(), idle_pct);
         end
      end
   endtask

   // Hold the stimulus until every queued request has gone out and answered.
   task automatic wait_drained();
      while (pending_requests.size() != 0 || expected_responses.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Driver: on a transfer, retire the head request into the expected queue,
   // then either idle or present the next one.
   always @(posedge clock) begin : drive_requests
      request_type head;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            head = pending_requests.pop_front();
            expected_responses.insert(expected_responses.size(), predict_codec(head));
         end
         // A request offered while busy stays on the ports untouched.
         if (!start || !busy) begin
            if (pending_requests.size() != 0 &&
                $urandom_range(99) >= pending_requests[0].idle_pct) begin
               head = pending_requests[0];
               start            <= 1'b1;
               req_type         <= head.kind;
               req_entropy_word <= head.entropy;
               req_first_index  <= head.idx0;
               req_second_index <= head.idx1;
               req_third_index  <= head.idx2;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: the strobe cannot be held off, so check every flagged cycle
   // against the oldest expectation.
   always @(posedge clock) begin : check_responses
      response_type want;
      if (!reset && rsp_strobe) begin
         if (expected_responses.size() == 0) begin
            report_mismatch("unexpected response word", 64'(rsp_word_out), 64'd0);
         end else begin
            want = expected_responses.pop_front();
            if (rsp_word_out !== want.word) begin
               report_mismatch("word_out", 64'(rsp_word_out), 64'(want.word));
            end
            if (rsp_overflowed !== want.ovf) begin
               report_mismatch("overflowed", 64'(rsp_overflowed), 64'(want.ovf));
            end
            if (rsp_index_a !== want.idx.a) begin
               report_mismatch("index_a", 64'(rsp_index_a), 64'(want.idx.a));
            end
            if (rsp_index_b !== want.idx.b) begin
               report_mismatch("index_b", 64'(rsp_index_b), 64'(want.idx.b));
            end
            if (rsp_index_c !== want.idx.c) begin
               report_mismatch("index_c", 64'(rsp_index_c), 64'(want.idx.c));
            end
            if (want.is_decode) begin
               decodes_checked++;
               if (want.ovf) begin
                  overflows_checked++;
               end
            end else begin
               encodes_checked++;
            end
         end
      end
   end

   // Watchdog: count cycles with neither a request nor a response transfer.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no transfer for %0d cycles", quiet_cycles);
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      triplet_type idx;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Encode corners: zero, digit boundaries, sign bit, alternating bits, all ones.
      queue_request(REQ_ENCODE, 32'd0, random_indices(), IDLE_NONE);
      queue_request(REQ_ENCODE, 32'd1, random_indices(), IDLE_NONE);
      queue_request(REQ_ENCODE, WORD_LIST_SIZE - 1, random_indices(), IDLE_NONE);
      queue_request(REQ_ENCODE, WORD_LIST_SIZE, random_indices(), IDLE_NONE);
      queue_request(REQ_ENCODE, WORD_LIST_SIZE * WORD_LIST_SIZE - 1, random_indices(),
                    IDLE_NONE);
      queue_request(REQ_ENCODE, WORD_LIST_SIZE * WORD_LIST_SIZE, random_indices(),
                    IDLE_NONE);
      queue_request(REQ_ENCODE, 32'h7FFF_FFFF, random_indices(), IDLE_NONE);
      queue_request(REQ_ENCODE, 32'h8000_0000, random_indices(), IDLE_NONE);
      queue_request(REQ_ENCODE, 32'h5555_5555, random_indices(), IDLE_NONE);
      queue_request(REQ_ENCODE, 32'hAAAA_AAAA, random_indices(), IDLE_NONE);
      queue_request(REQ_ENCODE, 32'hFFFF_FFFF, random_indices(), IDLE_NONE);

      // Decode corners: zero, top of the word range, first overflowing value, largest
      // decodable value, wrapping triplets, and indices at or above the list size.
      queue_request(REQ_DECODE, $urandom, chain_indices(64'd0), IDLE_NONE);
      queue_request(REQ_DECODE, $urandom, chain_indices(WORD_MAX), IDLE_NONE);
      queue_request(REQ_DECODE, $urandom, chain_indices(WORD_MAX + 1), IDLE_NONE);
      queue_request(REQ_DECODE, $urandom, chain_indices(TRIPLET_SPAN - 1), IDLE_NONE);
      idx = '{a: IDX_WIDTH'(WORD_LIST_SIZE - 1), b: IDX_WIDTH'(WORD_LIST_SIZE - 1),
              c: IDX_WIDTH'(WORD_LIST_SIZE - 1)};
      queue_request(REQ_DECODE, $urandom, idx, IDLE_NONE);
      idx = '{a: '0, b: IDX_WIDTH'(WORD_LIST_SIZE - 1), c: '0};
      queue_request(REQ_DECODE, $urandom, idx, IDLE_NONE);
      idx = '{a: IDX_WIDTH'(WORD_LIST_SIZE), b: IDX_WIDTH'(WORD_LIST_SIZE),
              c: IDX_WIDTH'(WORD_LIST_SIZE)};
      queue_request(REQ_DECODE, $urandom, idx, IDLE_NONE);
      idx = '{a: '1, b: '1, c: '1};
      queue_request(REQ_DECODE, $urandom, idx, IDLE_NONE);
      idx = '{a: '1, b: '0, c: IDX_WIDTH'(WORD_LIST_SIZE)};
      queue_request(REQ_DECODE, $urandom, idx, IDLE_NONE);
      idx = '{a: 11'h555, b: 11'h2AA, c: 11'h555};
      queue_request(REQ_DECODE, $urandom, idx, IDLE_NONE);
      wait_drained();

      // Random phases: back to back, sender mostly idle, sender lightly idle.
      // Each drain in between leaves the codec with nothing outstanding.
      queue_random_phase(PHASE_ITEMS, IDLE_NONE);
      wait_drained();
      queue_random_phase(PHASE_ITEMS, IDLE_HEAVY);
      wait_drained();
      queue_random_phase(PHASE_ITEMS, IDLE_LIGHT);
      wait_drained();

      // Let any stray response show up past the pipeline depth.
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d encodes and %0d decodes (%0d expected to overflow),",
               encodes_checked, decodes_checked, overflows_checked);
      $display("with back-to-back, 77%% and 23%% sender idle phases; %0d mismatches.",
               mismatches);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
